// ----- rtl/ldb_pkg.sv -----
// Shared constants, config codes and elaboration-time log table helpers.
`default_nettype none

package ldb_pkg;

  localparam int unsigned CH_W           = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned STAGES         = 8;
  localparam int unsigned LOG_SEGMENTS_DEF = 64;
  localparam int unsigned SERIES_TERMS   = 24;

  localparam logic [CH_W-1:0] ONE_Q15        = 16'd32768;
  localparam logic [CH_W-1:0] TWO_TENTHS_Q15 = 16'd6554;
  localparam logic [CH_W-1:0] INTENSITY_RST  = 16'd24576;
  localparam logic [CH_W-1:0] OPACITY_RST    = 16'd32768;

  // divide by 10 as multiply by reciprocal, exact for operands below 2^26
  localparam int unsigned    RECIP_SHIFT = 27;
  localparam int unsigned    RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY   = 2'd1;

  function automatic logic [CH_W-1:0] sat_one(input logic [CH_W-1:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  // restoring division, only used to build constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= d) begin
        r    = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/seg) in Q0.16 via 2*atanh(i/(2*seg+i))
  function automatic logic [CH_W-1:0] ln_point(input logic [63:0] i, input logic [63:0] seg);
    logic [63:0] den;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    den  = 64'd2 * seg + i;
    z    = udiv64(i << 30, den);
    z2   = (z * z) >> 30;
    term = z;
    sum  = '0;
    for (int n = 0; n < SERIES_TERMS; n++) begin
      sum  = sum + udiv64(term, 64'(2 * n + 1));
      term = (term * z2) >> 30;
    end
    res = (64'd2 * sum + 64'd8192) >> 14;
    return res[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ldb_channel.sv -----
// One color channel of the blend: eight register stages from log lookup to mix.
`default_nettype none

module ldb_channel
  import ldb_pkg::*;
#(
  parameter int unsigned LOG_SEGMENTS = LOG_SEGMENTS_DEF
) (
  input  wire logic              clk,
  input  wire logic [STAGES-1:0] en,
  input  wire logic [CH_W-1:0]   base,
  input  wire logic [CH_W-1:0]   layer,
  input  wire logic [CH_W-1:0]   k_q12,
  input  wire logic [CH_W-1:0]   opacity,
  output logic      [CH_W-1:0]   result
);

  localparam int unsigned SEG_W = $clog2(LOG_SEGMENTS + 1);
  localparam int unsigned POS_W = 15 + SEG_W;

  // constant ln(1+x) breakpoints
  logic [CH_W-1:0] ln_rom [0:LOG_SEGMENTS];
  for (genvar gi = 0; gi <= LOG_SEGMENTS; gi++) begin : g_rom
    assign ln_rom[gi] = ln_point(64'(gi), 64'(LOG_SEGMENTS));
  end

  // stage 1: difference and segment position
  logic [CH_W-1:0]  diff;
  logic [POS_W-1:0] pos;
  logic [SEG_W-1:0] s1_idx_r;
  logic [14:0]      s1_frac_r;
  logic [CH_W-1:0]  s1_b_r, s1_a_r;

  assign diff = (layer > base) ? (layer - base) : (base - layer);
  assign pos  = POS_W'(diff) * POS_W'(LOG_SEGMENTS);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_idx_r  <= pos[POS_W-1:15];
      s1_frac_r <= pos[14:0];
      s1_b_r    <= base;
      s1_a_r    <= layer;
    end
  end

  // stage 2: table read; top point reads itself as upper neighbor
  logic             last_seg;
  logic [SEG_W-1:0] hi_idx;
  logic [CH_W-1:0]  s2_lo_r, s2_dh_r, s2_b_r, s2_a_r;
  logic [14:0]      s2_frac_r;

  assign last_seg = (s1_idx_r == SEG_W'(LOG_SEGMENTS));
  assign hi_idx   = last_seg ? s1_idx_r : (s1_idx_r + SEG_W'(1));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_lo_r   <= ln_rom[s1_idx_r];
      s2_dh_r   <= ln_rom[hi_idx] - ln_rom[s1_idx_r];
      s2_frac_r <= s1_frac_r;
      s2_b_r    <= s1_b_r;
      s2_a_r    <= s1_a_r;
    end
  end

  // stage 3: interpolation
  logic [31:0]     interp;
  logic [CH_W-1:0] s3_ln_r, s3_b_r, s3_a_r;

  assign interp = 32'(s2_dh_r) * 32'(s2_frac_r) + 32'd16384;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_ln_r <= s2_lo_r + interp[30:15];
      s3_b_r  <= s2_b_r;
      s3_a_r  <= s2_a_r;
    end
  end

  // stage 4: k * ln, layer + 0.2
  logic [31:0]     s4_m1_r;
  logic [CH_W-1:0] s4_ap_r, s4_b_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_m1_r <= 32'(k_q12) * 32'(s3_ln_r);
      s4_ap_r <= s3_a_r + TWO_TENTHS_Q15;
      s4_b_r  <= s3_b_r;
    end
  end

  // stage 5: full Q43 product
  logic [47:0]     s5_prod_r;
  logic [CH_W-1:0] s5_b_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_prod_r <= 48'(s4_m1_r) * 48'(s4_ap_r);
      s5_b_r    <= s4_b_r;
    end
  end

  // stage 6: round, drop 2^28, scale by reciprocal of ten
  localparam int unsigned Q10_W = 21 + RECIP_W;
  logic [48:0]      rsum;
  logic [20:0]      t_div;
  logic [Q10_W-1:0] s6_q10_r;
  logic [CH_W-1:0]  s6_b_r;

  assign rsum  = 49'(s5_prod_r) + (49'd5 << 28);
  assign t_div = rsum[48:28];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_q10_r <= Q10_W'(t_div) * Q10_W'(RECIP_MUL);
      s6_b_r   <= s5_b_r;
    end
  end

  // stage 7: add increment, clamp at one, difference to base
  logic [17:0]     inc;
  logic [18:0]     psum;
  logic [CH_W-1:0] p_val;
  logic [CH_W-1:0] s7_d_r, s7_b_r;

  assign inc   = s6_q10_r[RECIP_SHIFT +: 18];
  assign psum  = 19'(s6_b_r) + 19'(inc);
  assign p_val = (psum > 19'(ONE_Q15)) ? ONE_Q15 : psum[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_d_r <= p_val - s6_b_r;
      s7_b_r <= s6_b_r;
    end
  end

  // stage 8: opacity mix
  logic [32:0]     mix_full;
  logic [16:0]     rsum8;
  logic [CH_W-1:0] s8_res_r;

  assign mix_full = 33'(opacity) * 33'(s7_d_r) + 33'd16384;
  assign rsum8    = 17'(s7_b_r) + mix_full[31:15];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_res_r <= (rsum8 > 17'(ONE_Q15)) ? ONE_Q15 : rsum8[CH_W-1:0];
    end
  end

  assign result = s8_res_r;

endmodule

`default_nettype wire

// ----- rtl/log_difference_blend.sv -----
// Log-difference blend: base/layer pixel in, blended pixel out, eight-stage pipeline.
//
// Input channel: in_valid / in_stall with base RGBA, layer RGB and a span-end
// flag; an item transfers when in_valid is high and in_stall low. Result
// channel: out_valid / out_stall, same transfer rule, with blended RGB, base
// alpha and the span-end flag. Config port: cfg_valid / cfg_ready, always
// ready; index 0 is intensity (Q4.12), index 1 is blend opacity (Q1.15);
// other indexes are dropped. Values above one (8.0 for intensity) saturate.
// Throughput is one pixel per cycle while out_stall is low, set by the eight
// register stages, each of which advances whenever it is empty or the stage
// after it moves.
// When the receiver stalls, the last stage holds and stages behind it keep
// filling their bubbles; in_stall rises only once every stage is occupied.
// Reset empties the pipeline and loads intensity 6.0 and opacity 1.0.
// Config writes are meant for idle periods only.
`default_nettype none

module log_difference_blend
  import ldb_pkg::*;
#(
  parameter int unsigned LOG_SEGMENTS = LOG_SEGMENTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input pixel channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CH_W-1:0]      in_base_red,
  input  wire logic [CH_W-1:0]      in_base_green,
  input  wire logic [CH_W-1:0]      in_base_blue,
  input  wire logic [CH_W-1:0]      in_base_alpha,
  input  wire logic [CH_W-1:0]      in_layer_red,
  input  wire logic [CH_W-1:0]      in_layer_green,
  input  wire logic [CH_W-1:0]      in_layer_blue,
  input  wire logic                 in_span_end,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [CH_W-1:0]      out_result_red,
  output logic      [CH_W-1:0]      out_result_green,
  output logic      [CH_W-1:0]      out_result_blue,
  output logic      [CH_W-1:0]      out_result_alpha,
  output logic                      out_span_end_out,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CH_W-1:0]      cfg_data
);

  // config registers, stored already saturated
  logic [CH_W-1:0] intensity_r, opacity_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r <= INTENSITY_RST;
      opacity_r   <= OPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INTENSITY: intensity_r <= sat_one(cfg_data);
        REG_OPACITY:   opacity_r   <= sat_one(cfg_data);
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  logic [STAGES-1:0] en;
  logic [STAGES-1:0] vld_r, vld_nxt;

  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || !out_stall;
    for (int s = STAGES - 2; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int s = 1; s < STAGES; s++) begin
      vld_nxt[s] = en[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[STAGES-1];

  // alpha and span flag ride alongside the color stages
  logic [CH_W-1:0] alpha_r [STAGES];
  logic [STAGES-1:0] span_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      alpha_r[0] <= sat_one(in_base_alpha);
      span_r[0]  <= in_span_end;
    end
    for (int s = 1; s < STAGES; s++) begin
      if (en[s]) begin
        alpha_r[s] <= alpha_r[s-1];
        span_r[s]  <= span_r[s-1];
      end
    end
  end

  assign out_result_alpha = alpha_r[STAGES-1];
  assign out_span_end_out = span_r[STAGES-1];

  ldb_channel #(.LOG_SEGMENTS(LOG_SEGMENTS)) u_red (
    .clk     (clk),
    .en      (en),
    .base    (sat_one(in_base_red)),
    .layer   (sat_one(in_layer_red)),
    .k_q12   (intensity_r),
    .opacity (opacity_r),
    .result  (out_result_red)
  );

  ldb_channel #(.LOG_SEGMENTS(LOG_SEGMENTS)) u_green (
    .clk     (clk),
    .en      (en),
    .base    (sat_one(in_base_green)),
    .layer   (sat_one(in_layer_green)),
    .k_q12   (intensity_r),
    .opacity (opacity_r),
    .result  (out_result_green)
  );

  ldb_channel #(.LOG_SEGMENTS(LOG_SEGMENTS)) u_blue (
    .clk     (clk),
    .en      (en),
    .base    (sat_one(in_base_blue)),
    .layer   (sat_one(in_layer_blue)),
    .k_q12   (intensity_r),
    .opacity (opacity_r),
    .result  (out_result_blue)
  );

endmodule

`default_nettype wire
